@@ sv/pus_pkg.sv @@
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; imported by the top level, the line store, the sequencer and the reconstruction stage.
package pus_pkg;

  // Line store geometry
  localparam int MAX_ROW_PIXELS = 4096;
  localparam int STORE_DEPTH    = MAX_ROW_PIXELS * 4;
  localparam int ADDR_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ROWB_W         = $clog2(STORE_DEPTH + 1);
  localparam int ROW_PIX_W      = $clog2(MAX_ROW_PIXELS + 1);

  // Configuration register widths and indexes
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filter_t;

  typedef struct packed {
    logic [12:0] pixels_per_row;
    logic [2:0]  bytes_per_pixel;
    logic [15:0] rows_per_image;
  } cfg_t;

  // One data byte on its way from the sequencer to the reconstruction stage
  typedef struct packed {
    logic [7:0]        stream_byte;
    logic [1:0]        channel;
    logic              first_pixel;
    logic              first_row;
    filter_t           filter;
    logic              row_end;
    logic              image_end;
    logic [ADDR_W-1:0] addr;
  } stage_t;

  // Paeth predictor: nearest of a, b, c to a+b-c, ties in the order a, b, c
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] res;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) res = a;
    else if (pb <= pc) res = b;
    else res = c;
    return res;
  endfunction

endpackage

@@ sv/png_scanline_unfilter.sv @@
// PNG scanline unfilter: takes one decompressed byte per cycle while in_ready is
// high and returns one reconstructed byte per data byte; the filter byte at the
// head of each row gives no result. Sustained rate is one byte per cycle while
// out_ready stays high, set by the line store having one read and one write
// port: each data byte is read at its row position when accepted and written
// back as it moves to the output register, so no two accesses meet on the same
// entry. An accepted data byte is held in the stage register and moves to the
// output register when that is free or being drained. The line store needs no
// clearing: on the first row of an image the upper bytes count as zero. Write
// configuration only while idle.
module png_scanline_unfilter import pus_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_stream_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pixel_byte,
  output logic [1:0]            out_channel_index,
  output logic                  out_row_end,
  output logic                  out_image_end
);

  cfg_t              cfg_r;
  logic              stage_vld;
  logic              stage_adv;
  stage_t            stage;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixels_per_row  <= 13'd1;
      cfg_r.bytes_per_pixel <= 3'd3;
      cfg_r.rows_per_image  <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXELS: cfg_r.pixels_per_row  <= cfg_wdata[12:0];
        CFG_BPP:    cfg_r.bytes_per_pixel <= cfg_wdata[2:0];
        CFG_ROWS:   cfg_r.rows_per_image  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  pus_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .stage_adv      (stage_adv),
    .stage_vld      (stage_vld),
    .stage          (stage),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr)
  );

  pus_line_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pus_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .stage_vld         (stage_vld),
    .stage             (stage),
    .stage_adv         (stage_adv),
    .rd_data           (rd_data),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_byte    (out_pixel_byte),
    .out_channel_index (out_channel_index),
    .out_row_end       (out_row_end),
    .out_image_end     (out_image_end)
  );

endmodule

@@ sv/pus_line_store.sv @@
// Prior-row line store: one write port, one read port, registered read data.
// Depends on pus_pkg for depth and address width.
module pus_line_store import pus_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  // Write reconstructed byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read; data holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/pus_front.sv @@
// Row sequencer: takes stream bytes, tracks filter, position and row count,
// issues the line-store read and holds one data byte for reconstruction. Uses pus_pkg.
module pus_front import pus_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_stream_byte,
  input  logic              stage_adv,
  output logic              stage_vld,
  output stage_t            stage,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr
);

  logic              awaiting_r, awaiting_nxt;
  logic              first_row_r, first_row_nxt;
  filter_t           filter_r, filter_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [1:0]        mod3_r, mod3_nxt;
  logic [15:0]       row_cnt_r, row_cnt_nxt;
  logic              stage_vld_r, stage_vld_nxt;
  stage_t            stage_r, stage_nxt;

  logic                 bpp4;
  logic [1:0]           ch;
  logic                 first_pix;
  logic [31:0]          pix32;
  logic [ROW_PIX_W-1:0] width_eff;
  logic [ROWB_W-1:0]    row_bytes;
  logic [15:0]          rows_eff;
  logic                 row_end;
  logic                 image_end;
  logic                 accept;

  // Effective geometry from the configuration
  always_comb begin
    bpp4      = (cfg.bytes_per_pixel >= 3'd4);
    ch        = bpp4 ? pos_r[1:0] : mod3_r;
    first_pix = bpp4 ? (pos_r < ADDR_W'(4)) : (pos_r < ADDR_W'(3));
    pix32     = 32'(cfg.pixels_per_row);
    if (pix32 == 32'd0) width_eff = ROW_PIX_W'(1);
    else if (pix32 > 32'(MAX_ROW_PIXELS)) width_eff = ROW_PIX_W'(MAX_ROW_PIXELS);
    else width_eff = ROW_PIX_W'(pix32);
    row_bytes = bpp4 ? (ROWB_W'(width_eff) << 2)
                     : (ROWB_W'(width_eff) + (ROWB_W'(width_eff) << 1));
    rows_eff  = (cfg.rows_per_image == 16'd0) ? 16'd1 : cfg.rows_per_image;
    row_end   = (ROWB_W'(pos_r) + ROWB_W'(1)) >= row_bytes;
    image_end = row_end && (({1'b0, row_cnt_r} + 17'd1) >= {1'b0, rows_eff});
  end

  assign in_ready = !stage_vld_r || stage_adv;
  assign accept   = in_valid && in_ready;
  assign rd_en    = accept && !awaiting_r;
  assign rd_addr  = pos_r;

  // Advance row state on each accepted request
  always_comb begin
    awaiting_nxt  = awaiting_r;
    first_row_nxt = first_row_r;
    filter_nxt    = filter_r;
    pos_nxt       = pos_r;
    mod3_nxt      = mod3_r;
    row_cnt_nxt   = row_cnt_r;
    stage_vld_nxt = stage_adv ? 1'b0 : stage_vld_r;
    stage_nxt     = stage_r;
    if (accept) begin
      if (awaiting_r) begin
        filter_nxt    = (in_stream_byte > {5'd0, FLT_PAETH}) ? FLT_NONE
                                                             : filter_t'(in_stream_byte[2:0]);
        awaiting_nxt  = 1'b0;
        pos_nxt       = '0;
        mod3_nxt      = 2'd0;
      end else begin
        stage_vld_nxt         = 1'b1;
        stage_nxt.stream_byte = in_stream_byte;
        stage_nxt.channel     = ch;
        stage_nxt.first_pixel = first_pix;
        stage_nxt.first_row   = first_row_r;
        stage_nxt.filter      = filter_r;
        stage_nxt.row_end     = row_end;
        stage_nxt.image_end   = image_end;
        stage_nxt.addr        = pos_r;
        if (row_end) begin
          awaiting_nxt  = 1'b1;
          pos_nxt       = '0;
          mod3_nxt      = 2'd0;
          if (image_end) begin
            row_cnt_nxt   = 16'd0;
            first_row_nxt = 1'b1;
          end else begin
            row_cnt_nxt   = row_cnt_r + 16'd1;
            first_row_nxt = 1'b0;
          end
        end else begin
          pos_nxt  = pos_r + ADDR_W'(1);
          // Track position modulo three for the RGB channel index
          mod3_nxt = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b1;
      first_row_r <= 1'b1;
      filter_r    <= FLT_NONE;
      pos_r       <= '0;
      mod3_r      <= 2'd0;
      row_cnt_r   <= 16'd0;
      stage_vld_r <= 1'b0;
    end else begin
      awaiting_r  <= awaiting_nxt;
      first_row_r <= first_row_nxt;
      filter_r    <= filter_nxt;
      pos_r       <= pos_nxt;
      mod3_r      <= mod3_nxt;
      row_cnt_r   <= row_cnt_nxt;
      stage_vld_r <= stage_vld_nxt;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign stage_vld = stage_vld_r;
  assign stage     = stage_r;

endmodule

@@ sv/pus_back.sv @@
// Reconstruction stage: forms the prediction from left, upper and upper-left
// bytes, writes the line store back and holds the output register. Uses pus_pkg.
module pus_back import pus_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              stage_vld,
  input  stage_t            stage,
  output logic              stage_adv,
  input  logic [7:0]        rd_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel_byte,
  output logic [1:0]        out_channel_index,
  output logic              out_row_end,
  output logic              out_image_end
);

  logic [7:0] left_r [4];
  logic [7:0] uleft_r [4];
  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_ch_r;
  logic       out_row_end_r;
  logic       out_img_end_r;

  logic [7:0] a, b, c, pred, rec;
  logic [8:0] sum_ab;

  // Prediction and reconstructed byte
  always_comb begin
    b      = stage.first_row ? 8'd0 : rd_data;
    a      = stage.first_pixel ? 8'd0 : left_r[stage.channel];
    c      = stage.first_pixel ? 8'd0 : uleft_r[stage.channel];
    sum_ab = {1'b0, a} + {1'b0, b};
    case (stage.filter)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = sum_ab[8:1];
      FLT_PAETH: pred = paeth(a, b, c);
      default:   pred = 8'd0;
    endcase
    rec = stage.stream_byte + pred;
  end

  // Move the stage into the output register when it is free or being drained
  assign stage_adv = stage_vld && (!out_vld_r || out_ready);
  assign wr_en     = stage_adv;
  assign wr_addr   = stage.addr;
  assign wr_data   = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        left_r[i]  <= 8'd0;
        uleft_r[i] <= 8'd0;
      end
    end else begin
      if (stage_adv) begin
        out_vld_r                <= 1'b1;
        left_r[stage.channel]  <= rec;
        uleft_r[stage.channel] <= b;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (stage_adv) begin
      out_byte_r    <= rec;
      out_ch_r      <= stage.channel;
      out_row_end_r <= stage.row_end;
      out_img_end_r <= stage.image_end;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_pixel_byte    = out_byte_r;
  assign out_channel_index = out_ch_r;
  assign out_row_end       = out_row_end_r;
  assign out_image_end     = out_img_end_r;

endmodule

@@ sv/pus_checker.sv @@
// Port-level checker for the PNG scanline unfilter, bound to the top level.
// Depends only on the top level's handshake and result ports.
module pus_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_stream_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_byte,
  input logic [1:0] out_channel_index,
  input logic       out_row_end,
  input logic       out_image_end
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_byte)
      && $stable(out_channel_index) && $stable(out_row_end) && $stable(out_image_end))
    else $error("stalled result changed");

  // Image end only on a row end
  a_image_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  // A waiting request holds its byte
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_stream_byte))
    else $error("waiting request changed");

endmodule

bind png_scanline_unfilter pus_checker u_pus_checker (.*);
